### rtl/mtsf_pkg.sv
// Shared types, constants and helper functions for the momentum tune span finder.
`default_nettype none
package mtsf_pkg;

    localparam int MAX_POINTS = 256;
    localparam int AW         = $clog2(MAX_POINTS);
    localparam int CW         = $clog2(MAX_POINTS + 1);

    localparam int OFF_W  = 32;
    localparam int TUNE_W = 18;
    localparam int DIFF_W = 24;
    localparam int SPAN_W = 17;
    localparam int ABS_W  = 31;

    localparam logic signed [TUNE_W-1:0] TUNE_ONE  = 18'sd65536;
    localparam logic signed [TUNE_W-1:0] TUNE_HALF = 18'sd32768;
    localparam logic signed [DIFF_W-1:0] DIFF_LIMIT_RESET = -24'sd327680;

    typedef struct packed {
        logic signed [OFF_W-1:0]  offset;
        logic signed [TUNE_W-1:0] tune_x;
        logic signed [TUNE_W-1:0] tune_y;
        logic signed [DIFF_W-1:0] diffusion;
    } t_point;

    localparam int POINT_W = $bits(t_point);

    // Control from the sequencer to the per-plane span trackers.
    typedef struct packed {
        logic init;
        logic restart;
        logic step;
        logic down;
    } t_span_ctl;

    function automatic logic tune_ok(input logic signed [TUNE_W-1:0] t);
        return (t > 18'sd0) && (t < TUNE_ONE);
    endfunction

    function automatic logic upper_half(input logic signed [TUNE_W-1:0] t);
        return t >= TUNE_HALF;
    endfunction

    // Absolute value that saturates the most negative offset.
    function automatic logic [ABS_W-1:0] abs_sat(input logic signed [OFF_W-1:0] d);
        logic [OFF_W-1:0] neg;
        neg = OFF_W'(-d);
        if (!d[OFF_W-1]) begin
            return d[ABS_W-1:0];
        end else if (neg[OFF_W-1]) begin
            return {ABS_W{1'b1}};
        end else begin
            return neg[ABS_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

### rtl/mtsf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module mtsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/mtsf_span.sv
// Per-plane walk tracker: side, activity, tune min/max and end offsets.
`default_nettype none
module mtsf_span
    import mtsf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_span_ctl                i_ctl,
    input  wire logic signed [TUNE_W-1:0] i_tune,
    input  wire logic signed [OFF_W-1:0]  i_offset,
    input  wire logic                     i_diff_ok,
    output logic                          o_cont,
    output logic [SPAN_W-1:0]             o_tune_span,
    output logic [ABS_W-1:0]              o_offset_span
);

    logic              r_active;
    logic              r_side;
    logic [SPAN_W-1:0] r_min;
    logic [SPAN_W-1:0] r_max;
    logic [ABS_W-1:0]  r_abs_lo;
    logic [ABS_W-1:0]  r_abs_hi;

    logic              ok;
    logic [SPAN_W-1:0] tune_u;
    logic [ABS_W-1:0]  abs_off;

    // Only the downward walk also looks at diffusion.
    assign ok      = tune_ok(i_tune) && (upper_half(i_tune) == r_side)
                     && (i_diff_ok || !i_ctl.down);
    assign o_cont  = r_active && ok;
    assign tune_u  = i_tune[SPAN_W-1:0];
    assign abs_off = abs_sat(i_offset);

    assign o_tune_span   = r_max - r_min;
    assign o_offset_span = (r_abs_lo < r_abs_hi) ? r_abs_lo : r_abs_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_ctl.init || i_ctl.restart) begin
            r_active <= 1'b1;
        end else if (i_ctl.step && r_active && !ok) begin
            r_active <= 1'b0;
        end

        if (i_ctl.init) begin
            r_side   <= upper_half(i_tune);
            r_min    <= tune_u;
            r_max    <= tune_u;
            r_abs_lo <= abs_off;
            r_abs_hi <= abs_off;
        end else if (i_ctl.step && o_cont) begin
            if (tune_u < r_min) begin
                r_min <= tune_u;
            end
            if (tune_u > r_max) begin
                r_max <= tune_u;
            end
            if (i_ctl.down) begin
                r_abs_lo <= abs_off;
            end else begin
                r_abs_hi <= abs_off;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/momentum_tune_span_finder_top.sv
// Top level of the momentum tune span finder: point store, sequencer and result register.
//
// Usage. A scan point is a request on start with its offset, two tunes, diffusion
// and the last_point flag; it is taken at a rising edge where start is high and
// busy is low. Points are written into the point memory in arrival order, one
// per cycle, and busy stays low while loading. Once the memory holds MAX_POINTS
// entries further points are dropped, but a dropped last point still triggers
// the analysis over the stored points.
// A request with last_point set raises busy and starts the analysis. The
// sequencer reads the memory through its single registered read port, each
// read passing through a read state and an evaluate state: first a search for
// the center point, then a downward walk and an upward walk with both planes
// tracked in parallel, then a final state that registers the result. The
// result appears on the o_ ports with o_strobe high for exactly one cycle; the
// receiver cannot stall it. The next request is accepted in the same cycle the
// strobe is shown. The user must write the diffusion limit through
// i_cfg_we / i_cfg_wdata only while idle; the block itself does not enforce it.
// Reset (synchronous, active low) empties the point count, restores the limit
// to -5.0 and returns the sequencer to idle; memory contents are not cleared,
// since only entries written in the current scan are ever read.
`default_nettype none
module momentum_tune_span_finder_top
    import mtsf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [OFF_W-1:0]  i_momentum_offset,
    input  wire logic signed [TUNE_W-1:0] i_tune_x,
    input  wire logic signed [TUNE_W-1:0] i_tune_y,
    input  wire logic signed [DIFF_W-1:0] i_diffusion,
    input  wire logic                     i_last_point,
    input  wire logic                     i_cfg_we,
    input  wire logic [DIFF_W-1:0]        i_cfg_wdata,
    output logic                          o_strobe,
    output logic [SPAN_W-1:0]             o_tune_span_x,
    output logic [ABS_W-1:0]              o_offset_span_x,
    output logic [SPAN_W-1:0]             o_tune_span_y,
    output logic [ABS_W-1:0]              o_offset_span_y
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_EV,
        S_DN_RD,
        S_DN_EV,
        S_UP_RD,
        S_UP_EV,
        S_FIN
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_n, n_n;
    logic [AW-1:0]            r_addr, n_addr;
    logic [AW-1:0]            r_c, n_c;
    logic                     r_found, n_found;
    logic signed [DIFF_W-1:0] r_limit;
    logic                     n_strobe;
    logic [SPAN_W-1:0]        n_tsx, n_tsy;
    logic [ABS_W-1:0]         n_osx, n_osy;

    logic         accept;
    logic         store_we;
    logic [CW-1:0] count_inc;
    t_point       wr_point;
    t_point       rd_point;
    logic [POINT_W-1:0] rd_data;
    logic         diff_ok;
    logic         center_ok;
    logic [CW-1:0] addr_next;
    logic [CW-1:0] c_next;
    t_span_ctl    ctl;
    logic         cont_x, cont_y;
    logic [SPAN_W-1:0] span_tx, span_ty;
    logic [ABS_W-1:0]  span_ox, span_oy;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign store_we = accept && (r_count != CW'(MAX_POINTS));
    assign count_inc = r_count + CW'(1);

    assign wr_point.offset    = i_momentum_offset;
    assign wr_point.tune_x    = i_tune_x;
    assign wr_point.tune_y    = i_tune_y;
    assign wr_point.diffusion = i_diffusion;

    mtsf_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_point),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign rd_point  = t_point'(rd_data);
    assign diff_ok   = (rd_point.diffusion <= r_limit);
    assign center_ok = tune_ok(rd_point.tune_x) && tune_ok(rd_point.tune_y)
                       && diff_ok && !rd_point.offset[OFF_W-1];
    assign addr_next = CW'(r_addr) + CW'(1);
    assign c_next    = CW'(r_c) + CW'(1);

    mtsf_span u_span_x (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_tune        (rd_point.tune_x),
        .i_offset      (rd_point.offset),
        .i_diff_ok     (diff_ok),
        .o_cont        (cont_x),
        .o_tune_span   (span_tx),
        .o_offset_span (span_ox)
    );

    mtsf_span u_span_y (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_tune        (rd_point.tune_y),
        .i_offset      (rd_point.offset),
        .i_diff_ok     (diff_ok),
        .o_cont        (cont_y),
        .o_tune_span   (span_ty),
        .o_offset_span (span_oy)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_addr   = r_addr;
        n_c      = r_c;
        n_found  = r_found;
        n_strobe = 1'b0;
        n_tsx    = o_tune_span_x;
        n_osx    = o_offset_span_x;
        n_tsy    = o_tune_span_y;
        n_osy    = o_offset_span_y;
        ctl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_last_point) begin
                        // The point count returns to zero for the next scan.
                        n_n     = store_we ? count_inc : r_count;
                        n_count = '0;
                        n_addr  = '0;
                        n_found = 1'b0;
                        n_state = S_SRCH_RD;
                    end else if (store_we) begin
                        n_count = count_inc;
                    end
                end
            end
            S_SRCH_RD: begin
                n_state = S_SRCH_EV;
            end
            S_SRCH_EV: begin
                if (center_ok) begin
                    n_found  = 1'b1;
                    n_c      = r_addr;
                    ctl.init = 1'b1;
                    if (r_addr != '0) begin
                        n_addr  = r_addr - AW'(1);
                        n_state = S_DN_RD;
                    end else if (addr_next < r_n) begin
                        n_addr  = addr_next[AW-1:0];
                        n_state = S_UP_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (addr_next < r_n) begin
                    n_addr  = addr_next[AW-1:0];
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_RD: begin
                n_state = S_DN_EV;
            end
            S_DN_EV: begin
                ctl.step = 1'b1;
                ctl.down = 1'b1;
                if ((cont_x || cont_y) && (r_addr != '0)) begin
                    n_addr  = r_addr - AW'(1);
                    n_state = S_DN_RD;
                end else begin
                    // Both planes start the upward walk from the center again.
                    ctl.restart = 1'b1;
                    if (c_next < r_n) begin
                        n_addr  = c_next[AW-1:0];
                        n_state = S_UP_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_UP_RD: begin
                n_state = S_UP_EV;
            end
            S_UP_EV: begin
                ctl.step = 1'b1;
                if ((cont_x || cont_y) && (addr_next < r_n)) begin
                    n_addr  = addr_next[AW-1:0];
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_strobe = 1'b1;
                n_tsx    = r_found ? span_tx : '0;
                n_osx    = r_found ? span_ox : '0;
                n_tsy    = r_found ? span_ty : '0;
                n_osy    = r_found ? span_oy : '0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_limit  <= DIFF_LIMIT_RESET;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_found  <= n_found;
            o_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
        r_n             <= n_n;
        r_addr          <= n_addr;
        r_c             <= n_c;
        o_tune_span_x   <= n_tsx;
        o_offset_span_x <= n_osx;
        o_tune_span_y   <= n_tsy;
        o_offset_span_y <= n_osy;
    end

endmodule
`default_nettype wire
